### design/sample_covariance_macros.svh
// Assertion macros for the sample covariance RTL (used by scov_ctrl).
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SAMPLE_COVARIANCE_MACROS_SVH
`define SAMPLE_COVARIANCE_MACROS_SVH

// same-cycle implication, held off during reset
`define SCOV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define SCOV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/scov_pkg.sv
// Shared widths, status codes and controller/datapath interface types
// for the sample covariance block. No dependencies.
package scov_pkg;

  localparam int SAMP_W      = 16;
  localparam int CNT_W       = 13;
  localparam int SUM_W       = 29;
  localparam int PSUM_W      = 44;
  localparam int PSPLIT      = 22;                 // low slice of product sum
  localparam int NUM_W       = 58;
  localparam int DEN_W       = 24;
  localparam int FRAC_W      = 8;
  localparam int DVD_W       = NUM_W + FRAC_W;
  localparam int COV_W       = 42;
  localparam int STAT_W      = 2;
  localparam int MAX_LEN_DEF = 4096;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    logic mul_first;   // Sa*Sb and n*(n-1)
    logic mul_lo;      // n * low slice of Sab
    logic mul_hi;      // n * high slice of Sab
    logic num_calc;    // combine into numerator
    logic div_start;
    logic load_out;    // load result word, clear sums
  } ctrl_cmd_t;

  typedef struct packed {
    logic overflow;
    logic short_len;
    logic div_busy;
  } dp_stat_t;

endpackage

### design/scov_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on scov_pkg.
module scov_div import scov_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quot
);

  localparam int IDX_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [DVD_W-1:0] dq_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] dsr_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             ge;

  assign rem_sh  = {rem_r, dq_r[DVD_W-1]};
  assign rem_dif = rem_sh - {1'b0, dsr_r};
  assign ge      = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = IDX_W'(DVD_W - 1);
    end else if (busy_r) begin
      if (idx_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      dq_r  <= {dq_r[DVD_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = dq_r;

endmodule

### design/scov_dp.sv
// Datapath: product stage, running sums, final multiplies and divide.
// Depends on scov_pkg and scov_div.
module scov_dp import scov_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  logic signed [SAMP_W-1:0] sample_a,
  input  logic signed [SAMP_W-1:0] sample_b,
  input  ctrl_cmd_t                cmd,
  output dp_stat_t                 stat,
  output logic signed [COV_W-1:0]  covariance_q8,
  output status_t                  status,
  output logic [CNT_W-1:0]         sample_count
);

  localparam int LO_W = CNT_W + PSPLIT;
  localparam int HI_W = CNT_W + 1 + PSUM_W - PSPLIT;

  // input stage: registered pair and its product
  logic                       stg_vld_r;
  logic signed [SAMP_W-1:0]   stg_a_r, stg_b_r;
  logic signed [2*SAMP_W-1:0] stg_p_r;

  logic [CNT_W-1:0]        cnt_r;
  logic                    ovf_r;
  logic signed [SUM_W-1:0] sum_a_r, sum_b_r;
  logic signed [PSUM_W-1:0] sum_p_r;

  logic signed [2*SUM_W-1:0] prod_ss_r;
  logic [2*CNT_W-1:0]        den_full;
  logic [DEN_W-1:0]          den_r;
  logic [LO_W-1:0]           lo_r;
  logic signed [HI_W-1:0]    hi_r;
  logic signed [NUM_W-1:0]   num_r;
  logic [NUM_W-1:0]          num_mag;
  logic [DVD_W-1:0]          quot;
  logic [COV_W-1:0]          cov_mag;
  logic                      div_busy;

  logic signed [COV_W-1:0] cov_r;
  status_t                 stat_r;
  logic [CNT_W-1:0]        cnt_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_a_r <= sample_a;
      stg_b_r <= sample_b;
      stg_p_r <= sample_a * sample_b;
    end
  end

  // accumulation; pairs past MAX_LEN only raise the overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      sum_p_r <= '0;
    end else if (stg_vld_r) begin
      if (cnt_r >= CNT_W'(MAX_LEN)) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r   <= cnt_r + 1'b1;
        sum_a_r <= sum_a_r + SUM_W'(stg_a_r);
        sum_b_r <= sum_b_r + SUM_W'(stg_b_r);
        sum_p_r <= sum_p_r + PSUM_W'(stg_p_r);
      end
    end
  end

  // numerator n*Sab - Sa*Sb, with n*Sab split in two slices
  assign den_full = cnt_r * (cnt_r - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.mul_first) begin
      prod_ss_r <= sum_a_r * sum_b_r;
      den_r     <= den_full[DEN_W-1:0];
    end
    if (cmd.mul_lo) begin
      lo_r <= cnt_r * sum_p_r[PSPLIT-1:0];
    end
    if (cmd.mul_hi) begin
      hi_r <= $signed({1'b0, cnt_r}) * $signed(sum_p_r[PSUM_W-1:PSPLIT]);
    end
    if (cmd.num_calc) begin
      num_r <= (NUM_W'(hi_r) <<< PSPLIT) + NUM_W'(lo_r) - NUM_W'(prod_ss_r);
    end
  end

  assign num_mag = num_r[NUM_W-1] ? (NUM_W'(0) - num_r) : num_r;

  scov_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({num_mag, FRAC_W'(0)}),
    .divisor  (den_r),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign cov_mag = quot[COV_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cnt_out_r <= cnt_r;
      if (ovf_r) begin
        stat_r <= ST_LONG;
        cov_r  <= '0;
      end else if (cnt_r < CNT_W'(2)) begin
        stat_r <= ST_SHORT;
        cov_r  <= '0;
      end else begin
        stat_r <= ST_OK;
        cov_r  <= num_r[NUM_W-1] ? (COV_W'(0) - cov_mag) : cov_mag;
      end
    end
  end

  assign stat.overflow  = ovf_r;
  assign stat.short_len = cnt_r < CNT_W'(2);
  assign stat.div_busy  = div_busy;

  assign covariance_q8 = cov_r;
  assign status        = stat_r;
  assign sample_count  = cnt_out_r;

endmodule

### design/scov_ctrl.sv
// Controller: sequences accumulation, final multiplies, divide and output.
// Depends on scov_pkg and sample_covariance_macros.svh.
`include "sample_covariance_macros.svh"

module scov_ctrl import scov_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tlast,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_ACC    = 9'b000000001,
    S_FLUSH  = 9'b000000010,
    S_MUL1   = 9'b000000100,
    S_MUL_LO = 9'b000001000,
    S_MUL_HI = 9'b000010000,
    S_NUM    = 9'b000100000,
    S_DIV_GO = 9'b001000000,
    S_DIV_WT = 9'b010000000,
    S_LOAD   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   in_fire;

  assign in_tready = (state_r == S_ACC);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_ACC: begin
        if (in_fire && in_tlast) state_nxt = S_FLUSH;
      end
      // last pair is summed during this cycle
      S_FLUSH: begin
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_first = 1'b1;
        state_nxt = (stat.overflow || stat.short_len) ? S_LOAD : S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_NUM;
      end
      S_NUM: begin
        cmd.num_calc = 1'b1;
        state_nxt    = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WT;
      end
      S_DIV_WT: begin
        if (!stat.div_busy) state_nxt = S_LOAD;
      end
      // wait for the output register to free up
      S_LOAD: begin
        if (!out_vld_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_ACC;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;

  `SCOV_ASSERT_NXT(a_last_flush, in_fire && in_tlast, state_r == S_FLUSH, "last word not flushed")
  `SCOV_ASSERT_NXT(a_load_valid, cmd.load_out, out_vld_r, "loaded result not presented")
  `SCOV_ASSERT_IMP(a_div_idle, state_r == S_ACC, !stat.div_busy, "divider busy while summing")

endmodule

### design/sample_covariance.sv
// Top level of the unbiased sample covariance block.
// Depends on scov_pkg, scov_ctrl, scov_dp (with scov_div).
//
//   channel | dir | tdata                              | tuser     | tlast
//   in_     | in  | [15:0] sample_a, [31:16] sample_b  | -         | last_sample
//   out_    | out | [41:0] covariance_q8,              | [1:0]     | -
//           |     | [54:42] sample_count, [55] zero    |   status  |
//
// Pairs are summed at one word per clock. After the last pair, input stalls
// while the controller flushes the last pair, builds the numerator, starts the
// divider, waits out its 66 radix-2 steps, sees it done and loads the result word.
// Short or overlong vectors go from the first multiply straight to the load.
// Reset (rst_n, synchronous, active low) clears the sums and the controller.
// A result waiting in the output register does not block the next vector;
// only the load of the next result waits for it to be taken.
module sample_covariance import scov_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // sample_a, sample_b
  input  logic                   in_tlast,   // last_sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // covariance_q8, sample_count, pad
  output logic [STAT_W-1:0]      out_tuser   // status
);

  ctrl_cmd_t               cmd;
  dp_stat_t                stat;
  logic                    in_fire;
  logic signed [COV_W-1:0] cov;
  status_t                 status;
  logic [CNT_W-1:0]        count;

  assign in_fire = in_tvalid && in_tready;

  scov_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  scov_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .sample_a      (in_tdata[SAMP_W-1:0]),
    .sample_b      (in_tdata[2*SAMP_W-1:SAMP_W]),
    .cmd           (cmd),
    .stat          (stat),
    .covariance_q8 (cov),
    .status        (status),
    .sample_count  (count)
  );

  assign out_tdata = {(OUT_TDATA_W - COV_W - CNT_W)'(0), count, cov};
  assign out_tuser = status;

endmodule

### verif/sample_covariance_tb.sv
// Self-checking testbench for sample_covariance: streams pair vectors and checks each
// covariance, status and count word against a built-in integer predictor.
// Depends on scov_pkg and the sample_covariance RTL only.
module sample_covariance_tb import scov_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxLen       = MAX_LEN_DEF;
  localparam int RandomPairs  = 1930;
  localparam int QuietTail    = 300;    // pending pairs below which nobody stalls
  localparam int DrainCycles  = 100;    // wait after the last result is checked
  localparam int WatchdogMax  = 5000;
  localparam int ReportMax    = 10;

  typedef struct {
    logic [SAMP_W-1:0] a;
    logic [SAMP_W-1:0] b;
    logic              last;
  } pair_t;

  typedef struct {
    logic signed [COV_W-1:0] cov;
    status_t                 status;
    logic [CNT_W-1:0]        count;
  } cov_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;

  pair_t       pending[$];
  cov_result_t cov_expected[$];

  // predictor state
  int          n_pairs = 0;
  longint      acc_a = 0;
  longint      acc_b = 0;
  longint      acc_ab = 0;
  bit          too_long = 1'b0;

  int          errors = 0;
  bit          quiet = 1'b0;
  int          in_gap = 0;
  int          in_pct = 10;
  int          out_gap = 0;
  int          out_pct = 10;
  int          pct_timer = 0;
  int          idle_cycles = 0;

  sample_covariance #(.MAX_LEN(MaxLen)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] sample_a, [31:16] sample_b
    .in_tlast   (in_tlast),    // last_sample
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [41:0] covariance_q8, [54:42] sample_count, [55] pad
    .out_tuser  (out_tuser)    // [1:0] status
  );

  always #1ns clk = ~clk;

  // Accumulate one accepted pair; on the last pair queue the expected word.
  function automatic void fold_pair(logic signed [SAMP_W-1:0] a,
                                    logic signed [SAMP_W-1:0] b, logic last);
    longint      n, num, den, q, r;
    cov_result_t res;
    if (n_pairs >= MaxLen) begin
      too_long = 1'b1;
    end else begin
      n_pairs++;
      acc_a  += longint'(a);
      acc_b  += longint'(b);
      acc_ab += longint'(a) * longint'(b);
    end
    if (!last) return;
    res.cov   = '0;
    res.count = n_pairs[CNT_W-1:0];
    if (too_long) begin
      res.status = ST_LONG;
    end else if (n_pairs < 2) begin
      res.status = ST_SHORT;
    end else begin
      n   = n_pairs;
      num = n * acc_ab - acc_a * acc_b;
      den = n * (n - 1);
      // quotient and remainder keep num*256 from overflowing; both truncate to zero
      q   = num / den;
      r   = num % den;
      res.cov    = COV_W'(q * 256 + (r * 256) / den);
      res.status = ST_OK;
    end
    cov_expected.insert(cov_expected.size(), res);
    n_pairs  = 0;
    acc_a    = 0;
    acc_b    = 0;
    acc_ab   = 0;
    too_long = 1'b0;
  endfunction

  task automatic push_pair(int a, int b, bit last);
    pair_t p;
    p.a    = SAMP_W'(a);
    p.b    = SAMP_W'(b);
    p.last = last;
    pending.insert(pending.size(), p);
  endtask

  // style 0: full range, 1: extremes and -1, 0, 1, 2: small values around zero
  task automatic add_vector(int len, int style);
    int ends[5];
    int va, vb;
    ends = '{-32768, 32767, -1, 0, 1};
    for (int i = 0; i < len; i++) begin
      case (style)
        0: begin
          va = $urandom_range(65535);
          vb = $urandom_range(65535);
        end
        1: begin
          va = ends[$urandom_range(4)];
          vb = ends[$urandom_range(4)];
        end
        default: begin
          va = int'($urandom_range(16)) - 8;
          vb = int'($urandom_range(16)) - 8;
        end
      endcase
      push_pair(va, vb, i == len - 1);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    pair_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        fold_pair(in_tdata[15:0], in_tdata[31:16], in_tlast);
      pct_timer++;
      if (pct_timer % 512 == 0) begin
        case ($urandom_range(2))
          0: in_pct = 0;
          1: in_pct = 10;
          default: in_pct = 35;
        endcase
        case ($urandom_range(2))
          0: out_pct = 0;
          1: out_pct = 10;
          default: out_pct = 35;
        endcase
      end
      quiet = pending.size() < QuietTail;
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(99) < in_pct) begin
          in_gap = $urandom_range(15);
          in_tvalid <= 1'b0;
        end else if (pending.size() != 0) begin
          p = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {p.b, p.a};
          in_tlast  <= p.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    cov_result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (cov_expected.size() == 0) begin
          errors++;
          if (errors <= ReportMax)
            $display("unexpected result word: cov %0d status %0d count %0d",
                     $signed(out_tdata[41:0]), out_tuser, out_tdata[54:42]);
        end else begin
          e = cov_expected.pop_front();
          if (out_tdata[41:0] !== e.cov || out_tuser !== e.status ||
              out_tdata[54:42] !== e.count) begin
            errors++;
            if (errors <= ReportMax)
              $display({"mismatch: cov exp %0d got %0d, status exp %0d got %0d,",
                        " count exp %0d got %0d"},
                       e.cov, $signed(out_tdata[41:0]), e.status, out_tuser,
                       e.count, out_tdata[54:42]);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < out_pct) begin
        out_gap = $urandom_range(15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // stall watchdog: any cycle without a handshake on either side counts
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchdogMax) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n_random, len, k;

    // single pairs: too few samples
    push_pair(32767, -32768, 1'b1);
    push_pair(-32768, 32767, 1'b1);
    // two pairs at the extremes, positive and negative covariance
    push_pair(-32768, -32768, 1'b0);
    push_pair(32767, 32767, 1'b1);
    push_pair(-32768, 32767, 1'b0);
    push_pair(32767, -32768, 1'b1);
    // constant vectors give zero
    push_pair(0, 0, 1'b0);
    push_pair(0, 0, 1'b0);
    push_pair(0, 0, 1'b1);
    // inexact quotients: truncation toward zero on both signs
    push_pair(1, 1, 1'b0);
    push_pair(0, 0, 1'b0);
    push_pair(0, 0, 1'b1);
    push_pair(1, -1, 1'b0);
    push_pair(0, 0, 1'b0);
    push_pair(0, 0, 1'b1);

    n_random = 0;
    while (n_random < RandomPairs) begin
      k = $urandom_range(99);
      if (k < 5)
        len = 1;
      else if (k < 10)
        len = $urandom_range(300, 100);
      else
        len = $urandom_range(40, 2);
      add_vector(len, $urandom_range(2));
      n_random += len;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_tvalid) @(posedge clk);
    while (cov_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/scov_pkg.sv
design/scov_div.sv
design/scov_dp.sv
design/scov_ctrl.sv
design/sample_covariance.sv
verif/sample_covariance_tb.sv
